>>> rtl/core/lfm_chirp_sample_generator_defines.svh
// ============================================================================
// LFM chirp generator assertion macros
// Shared helpers for writing clocked concurrent checks in one line each.
// ============================================================================
`ifndef LFM_CHIRP_SAMPLE_GENERATOR_DEFINES_SVH
`define LFM_CHIRP_SAMPLE_GENERATOR_DEFINES_SVH

// Check a property on every rising edge, suspended while reset is asserted.
`define LFMCG_ASSERT(lbl, clk, rst_n, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!(rst_n)) (prop)) \
        else $error(msg);

// Check a property on every rising edge, including edges in reset.
`define LFMCG_ASSERT_ALWAYS(lbl, clk, prop, msg) \
    lbl: assert property (@(posedge clk) (prop)) \
        else $error(msg);

`endif

>>> rtl/core/lfmcg_pkg.sv
// ============================================================================
// LFM chirp generator package
// Payload types, fixed widths and CORDIC constants for the chirp generator.
// ============================================================================
`timescale 1ns / 1ps
`default_nettype none

package lfmcg_pkg;

    // Output sample width, signed Q1.(OUTPUT_WIDTH-1).
    localparam int OUTPUT_WIDTH = 16;

    // Number of arctangent entries available to the rotator.
    localparam int ANGLE_TABLE_LEN = 24;

    // CORDIC start magnitude, 1/K with 30 fraction bits.
    localparam logic [31:0] GAIN_Q30 = 32'd652032874;

    // Quadrant codes taken from the top two angle bits.
    localparam logic [1:0] QUAD_FIRST  = 2'd0;
    localparam logic [1:0] QUAD_SECOND = 2'd1;
    localparam logic [1:0] QUAD_THIRD  = 2'd2;
    localparam logic [1:0] QUAD_FOURTH = 2'd3;

    // atan(2^-i) in turns, 2^32 per turn.
    localparam logic [31:0] ANGLE_STEP [ANGLE_TABLE_LEN] = '{
        32'h20000000, 32'h12E4051E, 32'h09FB385B, 32'h051111D4,
        32'h028B0D43, 32'h0145D7E1, 32'h00A2F61E, 32'h00517C55,
        32'h0028BE53, 32'h00145F2F, 32'h000A2F98, 32'h000517CC,
        32'h00028BE6, 32'h000145F3, 32'h0000A2FA, 32'h0000517D,
        32'h000028BE, 32'h0000145F, 32'h00000A30, 32'h00000518,
        32'h0000028C, 32'h00000146, 32'h000000A3, 32'h00000051
    };

    // Input transfer: sample time in signed Q8.24 and the last flag.
    typedef struct packed {
        logic signed [31:0] time_sample;
        logic               last_sample;
    } t_chirp_in;

    // Output transfer: cosine, sine and the forwarded last flag.
    typedef struct packed {
        logic signed [OUTPUT_WIDTH-1:0] in_phase;
        logic signed [OUTPUT_WIDTH-1:0] quadrature;
        logic                           last_out;
    } t_chirp_out;

endpackage

`default_nettype wire

>>> rtl/core/lfm_chirp_sample_generator.sv
// Throughput: one sample per cycle; busy stays low, since every step is its own
// register stage (abs, square, coefficient products, phase add, one CORDIC
// iteration per stage, round and saturate) and the receiver never stalls.
// Reset clears all valid bits and sets the chirp coefficient to zero.
// ============================================================================
// LFM chirp sample generator
// Maps each sample time t to cos and sin of the phase coef * t^2 (in turns),
// through a fully pipelined multiply path and a pipelined CORDIC rotator.
// ============================================================================
`timescale 1ns / 1ps
`default_nettype none
`include "lfm_chirp_sample_generator_defines.svh"

module lfm_chirp_sample_generator
    import lfmcg_pkg::*;
#(
    parameter int CORDIC_STAGES = 16
) (
    input  wire logic       i_clk,
    input  wire logic       i_rst_n,
    input  wire logic       start,
    output      logic       busy,
    input  wire t_chirp_in  i_sample,
    input  wire logic       i_cfg_we,
    input  wire logic [31:0] i_cfg_wdata,
    output      logic       o_strobe,
    output      t_chirp_out o_sample
);

    localparam int XW       = 33;
    localparam int CW       = XW + 1;
    localparam int DROP     = 31 - OUTPUT_WIDTH;
    localparam int RW       = CW + 1 - DROP;
    localparam int LATENCY  = CORDIC_STAGES + 5;
    localparam logic signed [RW-1:0] LIMIT_POS =
        RW'((64'sd1 <<< (OUTPUT_WIDTH - 1)) - 64'sd1);
    localparam logic signed [RW-1:0] LIMIT_NEG = -LIMIT_POS;
    localparam logic signed [CW:0] ROUND_HALF = (CW + 1)'(64'sd1 <<< (DROP - 1));
    localparam logic [OUTPUT_WIDTH-1:0] OUT_MOST_NEG = {1'b1, {(OUTPUT_WIDTH-1){1'b0}}};

    // The pipeline never holds off a transfer.
    assign busy = 1'b0;

    logic accept;
    assign accept = start && !busy;

    // Configuration register.
    logic [31:0] r_coef;
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_coef <= '0;
        end else if (i_cfg_we) begin
            r_coef <= i_cfg_wdata;
        end
    end

    // Valid bits of the front stages.
    logic r1_vld, r2_vld, r3_vld, r4_vld;
    logic r1_last, r2_last, r3_last, r4_last;

    // Stage 1: magnitude of the sample time; 2^31 fits as unsigned.
    logic [31:0] r1_mag;
    always_ff @(posedge i_clk) begin
        r1_mag  <= i_sample.time_sample[31] ? (~i_sample.time_sample + 32'd1)
                                            : i_sample.time_sample;
        r1_last <= i_sample.last_sample;
    end

    // Stage 2: exact square, Q16.48.
    logic [63:0] r2_sq;
    always_ff @(posedge i_clk) begin
        r2_sq   <= r1_mag * r1_mag;
        r2_last <= r1_last;
    end

    // Stage 3: both halves of the square times the coefficient, keeping only
    // the bits that land in the top word of the fraction of a turn.
    logic [63:0] prod_lo, prod_hi;
    logic [31:0] r3_part_lo, r3_part_hi;
    assign prod_lo = r2_sq[31:0]  * r_coef;
    assign prod_hi = r2_sq[63:32] * r_coef;
    always_ff @(posedge i_clk) begin
        r3_part_lo <= prod_lo[63:32];
        r3_part_hi <= prod_hi[31:0];
        r3_last    <= r2_last;
    end

    // Stage 4: phase angle, 2^32 per turn, wrapping modulo one turn.
    logic [31:0] n_angle, r4_angle;
    assign n_angle = r3_part_lo + r3_part_hi;
    always_ff @(posedge i_clk) begin
        r4_angle <= n_angle;
        r4_last  <= r3_last;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r1_vld <= 1'b0;
            r2_vld <= 1'b0;
            r3_vld <= 1'b0;
            r4_vld <= 1'b0;
        end else begin
            r1_vld <= accept;
            r2_vld <= r1_vld;
            r3_vld <= r2_vld;
            r4_vld <= r3_vld;
        end
    end

    // CORDIC pipeline: one rotation per stage, index k holds stage k output.
    logic signed [XW-1:0] r_cx [CORDIC_STAGES];
    logic signed [XW-1:0] r_cy [CORDIC_STAGES];
    logic signed [XW-1:0] r_cz [CORDIC_STAGES];
    logic [1:0]           r_cq [CORDIC_STAGES];
    logic                 r_cl [CORDIC_STAGES];
    logic                 r_cv [CORDIC_STAGES];

    for (genvar k = 0; k < CORDIC_STAGES; k++) begin : g_cordic
        logic signed [XW-1:0] x_in, y_in, z_in, step;
        logic [1:0]           q_in;
        logic                 l_in, v_in;

        // Stage inputs come from the phase register or the stage before.
        if (k == 0) begin : g_first
            assign x_in = $signed({1'b0, GAIN_Q30});
            assign y_in = '0;
            assign z_in = $signed({3'b000, r4_angle[29:0]});
            assign q_in = r4_angle[31:30];
            assign l_in = r4_last;
            assign v_in = r4_vld;
        end else begin : g_next
            assign x_in = r_cx[k-1];
            assign y_in = r_cy[k-1];
            assign z_in = r_cz[k-1];
            assign q_in = r_cq[k-1];
            assign l_in = r_cl[k-1];
            assign v_in = r_cv[k-1];
        end

        assign step = $signed({1'b0, ANGLE_STEP[k]});

        // Rotate toward zero residual angle.
        always_ff @(posedge i_clk) begin
            if (z_in >= 0) begin
                r_cx[k] <= x_in - (y_in >>> k);
                r_cy[k] <= y_in + (x_in >>> k);
                r_cz[k] <= z_in - step;
            end else begin
                r_cx[k] <= x_in + (y_in >>> k);
                r_cy[k] <= y_in - (x_in >>> k);
                r_cz[k] <= z_in + step;
            end
            r_cq[k] <= q_in;
            r_cl[k] <= l_in;
        end

        always_ff @(posedge i_clk) begin
            if (!i_rst_n) begin
                r_cv[k] <= 1'b0;
            end else begin
                r_cv[k] <= v_in;
            end
        end
    end

    // Round half up to the output precision and clamp symmetrically.
    function automatic logic [OUTPUT_WIDTH-1:0] round_sat(input logic signed [CW-1:0] v);
        logic signed [CW:0]   sum;
        logic signed [RW-1:0] r;
        sum = {v[CW-1], v} + ROUND_HALF;
        r   = RW'(sum >>> DROP);
        if (r > LIMIT_POS) begin
            r = LIMIT_POS;
        end else if (r < LIMIT_NEG) begin
            r = LIMIT_NEG;
        end
        return r[OUTPUT_WIDTH-1:0];
    endfunction

    // Quadrant rotation of the final vector.
    logic signed [XW-1:0] fx, fy;
    logic signed [CW-1:0] cos_v, sin_v;
    assign fx = r_cx[CORDIC_STAGES-1];
    assign fy = r_cy[CORDIC_STAGES-1];

    always_comb begin
        case (r_cq[CORDIC_STAGES-1])
            QUAD_FIRST: begin
                cos_v = CW'(fx);
                sin_v = CW'(fy);
            end
            QUAD_SECOND: begin
                cos_v = -CW'(fy);
                sin_v = CW'(fx);
            end
            QUAD_THIRD: begin
                cos_v = -CW'(fx);
                sin_v = -CW'(fy);
            end
            default: begin
                cos_v = CW'(fy);
                sin_v = -CW'(fx);
            end
        endcase
    end

    // Output register: each result is shown for one cycle under the strobe.
    t_chirp_out r_out;
    logic       r_strobe;
    always_ff @(posedge i_clk) begin
        r_out.in_phase   <= round_sat(cos_v);
        r_out.quadrature <= round_sat(sin_v);
        r_out.last_out   <= r_cl[CORDIC_STAGES-1];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_strobe <= 1'b0;
        end else begin
            r_strobe <= r_cv[CORDIC_STAGES-1];
        end
    end

    assign o_strobe = r_strobe;
    assign o_sample = r_out;

    // Every accepted transfer yields exactly one result after the fixed latency.
    `LFMCG_ASSERT(a_result_follows, i_clk, i_rst_n, accept |-> ##LATENCY o_strobe, "result missing after transfer")
    `LFMCG_ASSERT(a_no_spurious, i_clk, i_rst_n, o_strobe |-> $past(accept, LATENCY), "result without a transfer")
    `LFMCG_ASSERT(a_last_kept, i_clk, i_rst_n, o_strobe |-> (o_sample.last_out == $past(i_sample.last_sample, LATENCY)), "last flag not forwarded")
    `LFMCG_ASSERT(a_sat_range, i_clk, i_rst_n, o_strobe |-> ((o_sample.in_phase != OUT_MOST_NEG) && (o_sample.quadrature != OUT_MOST_NEG)), "output beyond saturation limit")
    `LFMCG_ASSERT_ALWAYS(a_reset_idle, i_clk, !i_rst_n |=> !o_strobe, "strobe raised right after reset")

endmodule

`default_nettype wire

>>> tb/lfm_chirp_sample_generator_tb.sv
// ============================================================================
// LFM chirp sample generator testbench
// Drives sample times into the chirp generator, predicts cos and sin of the
// chirp phase with a bit-exact CORDIC model, and checks every output sample
// in order. A short table of directed rows comes first, then random phases,
// each under its own chirp coefficient.
// ============================================================================
`timescale 1ns / 1ps

module lfm_chirp_sample_generator_tb;
    import lfmcg_pkg::*;

    localparam int CORDIC_STAGES = 16;
    localparam int ROTATOR_STAGES = (CORDIC_STAGES < 24) ? CORDIC_STAGES : 24;
    localparam int CYCLE_LIMIT = 200000;
    localparam int PHASE_COUNT = 6;
    localparam int PHASE_ITEMS = 105;
    localparam int DIRECTED_ROWS = 20;

    // Start magnitude of the rotator, 1/K with 30 fraction bits.
    localparam longint ROTATOR_GAIN = 64'd652032874;

    // Round-off dropped when going from 30 to OUTPUT_WIDTH-1 fraction bits.
    localparam int OUT_DROP = 31 - OUTPUT_WIDTH;
    localparam longint OUT_LIMIT = (64'sd1 <<< (OUTPUT_WIDTH - 1)) - 1;

    localparam logic signed [OUTPUT_WIDTH-1:0] FULL_SCALE = OUT_LIMIT[OUTPUT_WIDTH-1:0];

    // Arctangent of 2^-i, in units of 2^-32 turn.
    localparam longint TURN_STEP [24] = '{
        64'h20000000, 64'h12E4051E, 64'h09FB385B, 64'h051111D4,
        64'h028B0D43, 64'h0145D7E1, 64'h00A2F61E, 64'h00517C55,
        64'h0028BE53, 64'h00145F2F, 64'h000A2F98, 64'h000517CC,
        64'h00028BE6, 64'h000145F3, 64'h0000A2FA, 64'h0000517D,
        64'h000028BE, 64'h0000145F, 64'h00000A30, 64'h00000518,
        64'h0000028C, 64'h00000146, 64'h000000A3, 64'h00000051
    };

    // One directed row: coefficient in force, sample, and optional pinned outputs.
    typedef struct packed {
        logic [31:0]             coef;
        logic [31:0]             ts;
        logic                    last;
        logic                    pin_i;
        logic [OUTPUT_WIDTH-1:0] exp_i;
        logic                    pin_q;
        logic [OUTPUT_WIDTH-1:0] exp_q;
    } dir_row_t;

    logic        i_clk = 1'b0;
    logic        i_rst_n;
    logic        start;
    logic        busy;
    t_chirp_in   sample_bus;
    logic        i_cfg_we;
    logic [31:0] i_cfg_wdata;
    logic        o_strobe;
    t_chirp_out  result_bus;

    logic [31:0] chirp_coef = '0;
    t_chirp_out  chirp_expected_q [$];
    int          fail_count = 0;
    int          cycle_count = 0;
    dir_row_t    directed_rows [DIRECTED_ROWS];

    lfm_chirp_sample_generator #(
        .CORDIC_STAGES(CORDIC_STAGES)
    ) dut (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .start      (start),
        .busy       (busy),
        .i_sample   (sample_bus),
        .i_cfg_we   (i_cfg_we),
        .i_cfg_wdata(i_cfg_wdata),
        .o_strobe   (o_strobe),
        .o_sample   (result_bus)
    );

    always #10 i_clk = ~i_clk;

    // Run limit, counted in clock cycles.
    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("%0t: run limit reached", $time);
            $display("lfm_chirp_sample_generator regression: fail");
            $finish;
        end
    end

    // Round half up, then saturate to the symmetric output range.
    function automatic logic signed [OUTPUT_WIDTH-1:0] round_to_output(input longint v);
        longint r;
        r = (v + (64'sd1 <<< (OUT_DROP - 1))) >>> OUT_DROP;
        if (r > OUT_LIMIT) begin
            r = OUT_LIMIT;
        end
        if (r < -OUT_LIMIT) begin
            r = -OUT_LIMIT;
        end
        return r[OUTPUT_WIDTH-1:0];
    endfunction

    // Chirp sample for time ts under coefficient coef.
    function automatic t_chirp_out chirp_predict(input logic [31:0] ts, input logic last,
                                                 input logic [31:0] coef);
        logic [32:0] mag;
        logic [63:0] turns;
        logic [31:0] angle;
        longint      x, y, z, dx, dy, c, s;
        t_chirp_out  r;
        // The magnitude of the most negative time is 2^31, squared without overflow.
        mag = ts[31] ? (33'h1_0000_0000 - {1'b0, ts}) : {1'b0, ts};
        turns = {31'b0, mag} * {31'b0, mag};
        turns = turns * {32'b0, coef};
        angle = turns[63:32];
        z = longint'({34'b0, angle[29:0]});
        x = ROTATOR_GAIN;
        y = 0;
        for (int i = 0; i < ROTATOR_STAGES; i++) begin
            dx = y >>> i;
            dy = x >>> i;
            if (z >= 0) begin
                x = x - dx;
                y = y + dy;
                z = z - TURN_STEP[i];
            end else begin
                x = x + dx;
                y = y - dy;
                z = z + TURN_STEP[i];
            end
        end
        // Rotate the first-quadrant vector into the quadrant of the angle.
        case (angle[31:30])
            QUAD_FIRST: begin
                c = x;
                s = y;
            end
            QUAD_SECOND: begin
                c = -y;
                s = x;
            end
            QUAD_THIRD: begin
                c = -x;
                s = -y;
            end
            default: begin
                c = y;
                s = -x;
            end
        endcase
        r.in_phase = round_to_output(c);
        r.quadrature = round_to_output(s);
        r.last_out = last;
        return r;
    endfunction

    // Random sample time: mostly full range, some near zero, some extremes, some with the low 20 bits zero.
    function automatic logic [31:0] pick_time_sample();
        int kind;
        kind = $urandom_range(0, 9);
        if (kind < 5) begin
            return $urandom;
        end else if (kind < 8) begin
            return $urandom_range(0, 32'h0800_0000) - 32'h0400_0000;
        end else if (kind == 8) begin
            case ($urandom_range(0, 4))
                0: return 32'h8000_0000;
                1: return 32'h7FFF_FFFF;
                2: return 32'h0000_0000;
                3: return 32'h0000_0001;
                default: return 32'hFFFF_FFFF;
            endcase
        end else begin
            return {12'($urandom_range(0, 4095)), 20'h0};
        end
    endfunction

    // Gap length between transfers: mostly none, some short, a few long.
    function automatic int pick_gap();
        int r;
        r = $urandom_range(0, 99);
        if (r < 65) begin
            return 0;
        end else if (r < 92) begin
            return $urandom_range(1, 3);
        end
        return $urandom_range(10, 40);
    endfunction

    // Offer one sample and hold it until the block takes the transfer.
    task automatic drive_time_sample(input logic [31:0] ts, input logic last,
                                     input t_chirp_out want);
        @(negedge i_clk);
        start <= 1'b1;
        sample_bus <= '{time_sample: ts, last_sample: last};
        @(posedge i_clk);
        while (busy) begin
            @(posedge i_clk);
        end
        chirp_expected_q.push_back(want);
    endtask

    // Keep start low for the given number of cycles.
    task automatic hold_off(input int cycles);
        if (cycles > 0) begin
            @(negedge i_clk);
            start <= 1'b0;
            repeat (cycles - 1) @(negedge i_clk);
        end
    endtask

    // Stop offering and wait until every expected sample has come out.
    task automatic wait_for_drain();
        @(negedge i_clk);
        start <= 1'b0;
        while (chirp_expected_q.size() != 0) begin
            @(posedge i_clk);
        end
    endtask

    task automatic write_coefficient(input logic [31:0] value);
        @(negedge i_clk);
        i_cfg_we <= 1'b1;
        i_cfg_wdata <= value;
        @(posedge i_clk);
        chirp_coef = value;
        @(negedge i_clk);
        i_cfg_we <= 1'b0;
    endtask

    // Compare each output transfer with the oldest expected sample.
    always @(posedge i_clk) begin : result_check
        t_chirp_out want;
        if (i_rst_n && o_strobe) begin
            if (chirp_expected_q.size() == 0) begin
                $display("%0t: unexpected sample, expected none, got I=%0d Q=%0d last=%0b",
                         $time, result_bus.in_phase, result_bus.quadrature,
                         result_bus.last_out);
                fail_count++;
            end else begin
                want = chirp_expected_q.pop_front();
                if (result_bus.in_phase !== want.in_phase) begin
                    $display("%0t: in_phase mismatch, expected %0d, got %0d",
                             $time, want.in_phase, result_bus.in_phase);
                    fail_count++;
                end
                if (result_bus.quadrature !== want.quadrature) begin
                    $display("%0t: quadrature mismatch, expected %0d, got %0d",
                             $time, want.quadrature, result_bus.quadrature);
                    fail_count++;
                end
                if (result_bus.last_out !== want.last_out) begin
                    $display("%0t: last_out mismatch, expected %0b, got %0b",
                             $time, want.last_out, result_bus.last_out);
                    fail_count++;
                end
            end
        end
    end

    initial begin : stimulus
        t_chirp_out  want;
        dir_row_t    row;
        logic [31:0] ts;
        logic [31:0] coef_pick;
        logic        last;
        bit          gaps_on;

        i_rst_n = 1'b0;
        start = 1'b0;
        sample_bus = '0;
        i_cfg_we = 1'b0;
        i_cfg_wdata = '0;

        // Pinned outputs are the ones the rotator saturates: the angle sits on an axis.
        directed_rows = '{
            // Coefficient after reset is zero, so every angle is zero.
            '{32'h0000_0000, 32'h0000_0000, 1'b0, 1'b1, FULL_SCALE, 1'b0, '0},
            '{32'h0000_0000, 32'h7FFF_FFFF, 1'b1, 1'b1, FULL_SCALE, 1'b0, '0},
            '{32'h0000_0000, 32'h8000_0000, 1'b0, 1'b1, FULL_SCALE, 1'b0, '0},
            // One turn per unit squared: whole turns wrap away.
            '{32'h0001_0000, 32'h8000_0000, 1'b0, 1'b1, FULL_SCALE, 1'b0, '0},
            '{32'h0001_0000, 32'h0100_0000, 1'b0, 1'b1, FULL_SCALE, 1'b0, '0},
            '{32'h0001_0000, 32'hFF00_0000, 1'b1, 1'b1, FULL_SCALE, 1'b0, '0},
            '{32'h0001_0000, 32'h0080_0000, 1'b0, 1'b0, '0, 1'b1, FULL_SCALE},
            '{32'h0001_0000, 32'hFF80_0000, 1'b1, 1'b0, '0, 1'b1, FULL_SCALE},
            '{32'h0001_0000, 32'h00B5_04F3, 1'b0, 1'b0, '0, 1'b0, '0},
            // Half a turn lands in the third quadrant.
            '{32'h0000_8000, 32'h0100_0000, 1'b0, 1'b1, -FULL_SCALE, 1'b0, '0},
            '{32'h0000_8000, 32'hFF00_0000, 1'b1, 1'b1, -FULL_SCALE, 1'b0, '0},
            '{32'h0000_8000, 32'h0080_0000, 1'b0, 1'b0, '0, 1'b0, '0},
            // Three quarters of a turn lands in the fourth quadrant.
            '{32'h0000_C000, 32'h0100_0000, 1'b0, 1'b0, '0, 1'b1, -FULL_SCALE},
            '{32'h0000_C000, 32'h0000_0001, 1'b1, 1'b0, '0, 1'b0, '0},
            // Largest coefficient, with phase overflow on large times.
            '{32'hFFFF_FFFF, 32'h0000_0000, 1'b0, 1'b1, FULL_SCALE, 1'b0, '0},
            '{32'hFFFF_FFFF, 32'h7FFF_FFFF, 1'b0, 1'b0, '0, 1'b0, '0},
            '{32'hFFFF_FFFF, 32'h8000_0000, 1'b0, 1'b0, '0, 1'b1, -FULL_SCALE},
            '{32'hFFFF_FFFF, 32'h0000_0001, 1'b1, 1'b0, '0, 1'b0, '0},
            '{32'hFFFF_FFFF, 32'hFFFF_FFFF, 1'b0, 1'b0, '0, 1'b0, '0},
            '{32'hFFFF_FFFF, 32'h1234_5678, 1'b1, 1'b0, '0, 1'b0, '0}
        };

        repeat (12) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        // Directed rows, back to back; the coefficient changes only when idle.
        for (int k = 0; k < DIRECTED_ROWS; k++) begin
            row = directed_rows[k];
            if (row.coef != chirp_coef) begin
                wait_for_drain();
                write_coefficient(row.coef);
            end
            want = chirp_predict(row.ts, row.last, chirp_coef);
            if (row.pin_i) begin
                want.in_phase = row.exp_i;
            end
            if (row.pin_q) begin
                want.quadrature = row.exp_q;
            end
            drive_time_sample(row.ts, row.last, want);
        end

        // Random phases, each under its own coefficient; each boundary is a full drain.
        for (int phase = 0; phase < PHASE_COUNT; phase++) begin
            wait_for_drain();
            case (phase)
                0: coef_pick = 32'hFFFF_FFFF;
                1: coef_pick = 32'h0000_0000;
                3: coef_pick = $urandom_range(1, 32'h0001_FFFF);
                5: coef_pick = $urandom_range(32'h0001_0000, 32'h0010_0000);
                default: coef_pick = $urandom;
            endcase
            write_coefficient(coef_pick);
            gaps_on = (phase % 3) != 1;
            for (int k = 0; k < PHASE_ITEMS; k++) begin
                ts = pick_time_sample();
                last = ($urandom_range(0, 7) == 0);
                want = chirp_predict(ts, last, chirp_coef);
                drive_time_sample(ts, last, want);
                if (gaps_on) begin
                    hold_off(pick_gap());
                end
            end
        end

        // Let the pipeline settle so that a stray output would still be seen.
        wait_for_drain();
        repeat (CORDIC_STAGES + 8) @(posedge i_clk);
        if (chirp_expected_q.size() != 0) begin
            $display("%0t: %0d expected samples never came out",
                     $time, chirp_expected_q.size());
            fail_count++;
        end
        if (fail_count == 0) begin
            $display("lfm_chirp_sample_generator regression: pass");
        end else begin
            $display("lfm_chirp_sample_generator regression: fail");
        end
        $finish;
    end

endmodule

>>> filelist.f
+incdir+rtl/core
rtl/core/lfmcg_pkg.sv
rtl/core/lfm_chirp_sample_generator.sv
tb/lfm_chirp_sample_generator_tb.sv
